FILE: design/status_led_pattern_generator_assert.svh
// ----------------------------------------------------------------------------
// Status LED pattern generator assertion macros
// Shorthands for clocked concurrent checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_PATTERN_GENERATOR_ASSERT_SVH
`define STATUS_LED_PATTERN_GENERATOR_ASSERT_SVH

// Same-cycle implication
`define SLPG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SLPG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/slpg_pkg.sv
// ----------------------------------------------------------------------------
// Status LED pattern generator package
// Shared types, operation and pattern codes, register map and reset values.
// ----------------------------------------------------------------------------
package slpg_pkg;

	typedef logic [1:0] op_t;
	typedef logic [2:0] pattern_t;

	localparam op_t OP_POLL     = 2'd0;
	localparam op_t OP_SET      = 2'd1;
	localparam op_t OP_IDENTIFY = 2'd2;

	localparam pattern_t PAT_OFF        = 3'd0;
	localparam pattern_t PAT_IDLE       = 3'd1;
	localparam pattern_t PAT_RECEIVING  = 3'd2;
	localparam pattern_t PAT_INSTALLING = 3'd3;
	localparam pattern_t PAT_ERROR      = 3'd4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int FIELD_TIME_W = 32;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_IDLE_HALF     = 3'd0;
	localparam cfg_index_t REG_RECEIVE_HALF  = 3'd1;
	localparam cfg_index_t REG_BURST_HALF    = 3'd2;
	localparam cfg_index_t REG_BURST_PAUSE   = 3'd3;
	localparam cfg_index_t REG_BURST_TOGGLES = 3'd4;
	localparam cfg_index_t REG_IDENTIFY_HALF = 3'd5;

	typedef struct packed {
		logic [15:0] idle_half;
		logic [15:0] receive_half;
		logic [15:0] burst_half;
		logic [15:0] burst_pause;
		logic [3:0]  burst_toggles;
		logic [15:0] identify_half;
	} slpg_cfg_t;

	localparam slpg_cfg_t CFG_RESET = '{
		idle_half:     16'd500,
		receive_half:  16'd100,
		burst_half:    16'd80,
		burst_pause:   16'd600,
		burst_toggles: 4'd6,
		identify_half: 16'd100
	};

	// Error pins the LED on, off pins it dark; other patterns keep the level
	function automatic logic forced_level(pattern_t pat, logic cur);
		logic lvl;
		lvl = cur;
		if (pat == PAT_ERROR) begin
			lvl = 1'b1;
		end else if (pat == PAT_OFF) begin
			lvl = 1'b0;
		end
		return lvl;
	endfunction

endpackage

FILE: design/slpg_item_if.sv
// ----------------------------------------------------------------------------
// Item channel
// Valid/ready channel carrying one poll, pattern change or identify request.
// ----------------------------------------------------------------------------
interface slpg_item_if import slpg_pkg::*; ();
	logic        valid;
	logic        ready;
	op_t         operation;
	logic [31:0] now_ms;
	pattern_t    pattern_sel;
	logic [31:0] identify_duration_ms;

	modport source (
		output valid, operation, now_ms, pattern_sel, identify_duration_ms,
		input  ready
	);
	modport sink (
		input  valid, operation, now_ms, pattern_sel, identify_duration_ms,
		output ready
	);
endinterface

FILE: design/slpg_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the LED level after each item.
// ----------------------------------------------------------------------------
interface slpg_result_if import slpg_pkg::*; ();
	logic valid;
	logic ready;
	logic led_on;

	modport source (output valid, led_on, input ready);
	modport sink (input valid, led_on, output ready);
endinterface

FILE: design/slpg_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface slpg_cfg_if import slpg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	cfg_index_t            index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/status_led_pattern_generator.sv
// ----------------------------------------------------------------------------
// Status LED pattern generator
// Drives one status LED level from timestamped poll, pattern and identify items.
// ----------------------------------------------------------------------------
//  channel  | role   | payload
//  ---------+--------+-------------------------------------------------------
//  item     | sink   | operation, now_ms, pattern_sel, identify_duration_ms
//  result   | source | led_on
//  cfg      | sink   | index, data (register write, always ready)
//
//  An item is registered on entry and its result registered as it leaves the
//  entry register; one item per cycle sustained while results are taken.
//  The pattern state updates as the item leaves the entry register, so the
//  next item sees it at once. A stalled result holds the entry register; a
//  new item is then taken only while the entry register is empty.
//  Reset returns the off pattern, no identify, LED dark and default intervals.
// ----------------------------------------------------------------------------
module status_led_pattern_generator import slpg_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	slpg_item_if.sink     item,
	slpg_result_if.source result,
	slpg_cfg_if.sink      cfg
);

	slpg_cfg_t   regs;

	logic        valid_s1;
	op_t         operation_s1;
	logic [31:0] now_ms_s1;
	pattern_t    pattern_sel_s1;
	logic [31:0] duration_s1;

	logic        valid_s2;
	logic        led_on_s2;

	logic        advance;
	logic        led_next;

	slpg_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// move the entry item on whenever the result slot is free or draining
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			operation_s1   <= item.operation;
			now_ms_s1      <= item.now_ms;
			pattern_sel_s1 <= item.pattern_sel;
			duration_s1    <= item.identify_duration_ms;
		end
	end

	slpg_engine #(
		.TIME_BITS (TIME_BITS)
	) u_engine (
		.clk                  (clk),
		.arst_n               (arst_n),
		.step                 (advance),
		.operation            (operation_s1),
		.now_ms               (now_ms_s1),
		.pattern_sel          (pattern_sel_s1),
		.identify_duration_ms (duration_s1),
		.regs                 (regs),
		.led_next             (led_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_on_s2 <= led_next;
		end
	end

	assign result.valid  = valid_s2;
	assign result.led_on = led_on_s2;

endmodule

FILE: design/slpg_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the blink intervals and burst settings; always ready to take a write.
// ----------------------------------------------------------------------------
module slpg_cfg_regs import slpg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	slpg_cfg_if.sink   cfg,
	output slpg_cfg_t  regs
);

	slpg_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_IDLE_HALF:     regs_q.idle_half     <= cfg.data;
				REG_RECEIVE_HALF:  regs_q.receive_half  <= cfg.data;
				REG_BURST_HALF:    regs_q.burst_half    <= cfg.data;
				REG_BURST_PAUSE:   regs_q.burst_pause   <= cfg.data;
				REG_BURST_TOGGLES: regs_q.burst_toggles <= cfg.data[3:0];
				REG_IDENTIFY_HALF: regs_q.identify_half <= cfg.data;
				default: begin
					// drop writes outside the register map
				end
			endcase
		end
	end

endmodule

FILE: design/slpg_engine.sv
// ----------------------------------------------------------------------------
// Pattern engine
// Holds the pattern state and works out the next LED level for one item.
// ----------------------------------------------------------------------------
`include "status_led_pattern_generator_assert.svh"

module slpg_engine import slpg_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  op_t         operation,
	input  logic [31:0] now_ms,
	input  pattern_t    pattern_sel,
	input  logic [31:0] identify_duration_ms,
	input  slpg_cfg_t   regs,
	output logic        led_next
);

	logic [63:0]          now_wide;
	logic [63:0]          dur_wide;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] dur_t;

	pattern_t             pattern_q;
	logic [TIME_BITS-1:0] last_toggle_q;
	logic [3:0]           burst_done_q;
	logic [TIME_BITS-1:0] deadline_q;
	logic                 led_q;

	pattern_t             pattern_d;
	logic [TIME_BITS-1:0] last_toggle_d;
	logic [3:0]           burst_done_d;
	logic [TIME_BITS-1:0] deadline_d;
	logic                 led_d;

	logic [TIME_BITS-1:0] elapsed;
	logic [TIME_BITS-1:0] to_deadline;
	logic [TIME_BITS-1:0] new_deadline;
	logic                 identify_on;
	logic                 deadline_hit;

	assign now_wide = 64'(now_ms);
	assign dur_wide = 64'(identify_duration_ms);
	assign now_t    = now_wide[TIME_BITS-1:0];
	assign dur_t    = dur_wide[TIME_BITS-1:0];

	assign elapsed      = now_t - last_toggle_q;
	assign to_deadline  = now_t - deadline_q;
	assign new_deadline = now_t + dur_t;
	assign identify_on  = (deadline_q != '0);
	// reached once the wrapped difference is non-negative
	assign deadline_hit = !to_deadline[TIME_BITS-1];

	always_comb begin
		pattern_d     = pattern_q;
		last_toggle_d = last_toggle_q;
		burst_done_d  = burst_done_q;
		deadline_d    = deadline_q;
		led_d         = led_q;

		unique case (operation)
			OP_POLL: begin
				if (identify_on) begin
					if (deadline_hit) begin
						deadline_d    = '0;
						last_toggle_d = now_t;
						burst_done_d  = 4'd0;
						led_d         = forced_level(pattern_q, led_q);
					end else if (elapsed >= TIME_BITS'(regs.identify_half)) begin
						led_d         = !led_q;
						last_toggle_d = now_t;
					end
				end else begin
					unique case (pattern_q)
						PAT_IDLE: begin
							if (elapsed >= TIME_BITS'(regs.idle_half)) begin
								led_d         = !led_q;
								last_toggle_d = now_t;
							end
						end
						PAT_RECEIVING: begin
							if (elapsed >= TIME_BITS'(regs.receive_half)) begin
								led_d         = !led_q;
								last_toggle_d = now_t;
							end
						end
						PAT_INSTALLING: begin
							if (burst_done_q < regs.burst_toggles) begin
								if (elapsed >= TIME_BITS'(regs.burst_half)) begin
									led_d         = !led_q;
									last_toggle_d = now_t;
									burst_done_d  = burst_done_q + 4'd1;
								end
							end else if (elapsed >= TIME_BITS'(regs.burst_pause)) begin
								// pause over: restart the burst
								burst_done_d  = 4'd0;
								last_toggle_d = now_t;
							end
						end
						default: begin
							// off and error hold their level
						end
					endcase
				end
			end
			OP_SET: begin
				if (pattern_sel <= PAT_ERROR && pattern_sel != pattern_q) begin
					pattern_d     = pattern_sel;
					burst_done_d  = 4'd0;
					last_toggle_d = now_t;
					led_d         = forced_level(pattern_sel, led_q);
				end
			end
			OP_IDENTIFY: begin
				// zero marks identify as inactive, so nudge it to one
				deadline_d    = (new_deadline == '0) ? TIME_BITS'(1) : new_deadline;
				last_toggle_d = now_t;
				led_d         = 1'b1;
			end
			default: begin
				// unused operation code changes nothing
			end
		endcase
	end

	assign led_next = led_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q     <= PAT_OFF;
			last_toggle_q <= '0;
			burst_done_q  <= 4'd0;
			deadline_q    <= '0;
			led_q         <= 1'b0;
		end else if (step) begin
			pattern_q     <= pattern_d;
			last_toggle_q <= last_toggle_d;
			burst_done_q  <= burst_done_d;
			deadline_q    <= deadline_d;
			led_q         <= led_d;
		end
	end

	`SLPG_ASSERT_NEXT(a_identify_arms, step && operation == OP_IDENTIFY,
		deadline_q != '0 && led_q, "identify did not arm the deadline and light the LED")
	`SLPG_ASSERT_NEXT(a_error_lit,
		step && operation == OP_SET && pattern_sel == PAT_ERROR && pattern_q != PAT_ERROR,
		pattern_q == PAT_ERROR && led_q, "error pattern not solid on")
	`SLPG_ASSERT_NEXT(a_hold_idle, !step,
		$stable(led_q) && $stable(pattern_q) && $stable(deadline_q),
		"pattern state moved without an item")
	`SLPG_ASSERT_NOW(a_off_dark, !identify_on && pattern_q == PAT_OFF,
		!led_q, "LED lit in off pattern without identify")

endmodule

FILE: sim/tb_status_led_pattern_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Status LED pattern generator testbench
// Sends poll, pattern and identify items with a moving millisecond clock and
// keeps its own model of the LED state. Each result level is compared with
// the model. A directed part comes first, then random traffic in several
// register settings and with several amounts of idling on both sides.
// ----------------------------------------------------------------------------
module tb_status_led_pattern_generator;
	import slpg_pkg::*;

	localparam op_t      OP_UNKNOWN     = 2'd3;
	localparam pattern_t PAT_UNUSED     = 3'd7;
	localparam int       WATCHDOG_LIMIT = 2000;
	localparam int       PHASE_COUNT    = 6;
	localparam int       PHASE_ITEMS    = 290;

	logic clk;
	logic arst_n;

	slpg_item_if   item_ch();
	slpg_result_if result_ch();
	slpg_cfg_if    cfg_ch();

	status_led_pattern_generator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// LED model state and register copy
	slpg_cfg_t   cfg_shadow;
	pattern_t    led_pattern;
	logic [31:0] toggle_stamp;
	logic [31:0] identify_end;
	logic [3:0]  burst_count;
	logic        led_level;

	logic        led_expected[$];
	int          error_count;
	int          idle_mode;
	int          stall_pct;
	int          quiet_cycles;
	logic [31:0] sim_now;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void toggle_led(input logic [31:0] now);
		led_level    = ~led_level;
		toggle_stamp = now;
	endfunction

	function automatic void pin_for_pattern();
		if (led_pattern == PAT_ERROR) begin
			led_level = 1'b1;
		end else if (led_pattern == PAT_OFF) begin
			led_level = 1'b0;
		end
	endfunction

	function automatic logic predict_led(input op_t op, input logic [31:0] now,
			input pattern_t sel, input logic [31:0] dur);
		logic [31:0] elapsed;
		logic [31:0] past_end;
		elapsed  = now - toggle_stamp;
		past_end = now - identify_end;
		case (op)
			OP_POLL: begin
				if (identify_end != '0) begin
					// deadline reached once the wrapped difference is not negative
					if (!past_end[31]) begin
						identify_end = '0;
						toggle_stamp = now;
						burst_count  = '0;
						pin_for_pattern();
					end else if (elapsed >= {16'd0, cfg_shadow.identify_half}) begin
						toggle_led(now);
					end
				end else begin
					case (led_pattern)
						PAT_IDLE: begin
							if (elapsed >= {16'd0, cfg_shadow.idle_half}) toggle_led(now);
						end
						PAT_RECEIVING: begin
							if (elapsed >= {16'd0, cfg_shadow.receive_half}) toggle_led(now);
						end
						PAT_INSTALLING: begin
							if (burst_count < cfg_shadow.burst_toggles) begin
								if (elapsed >= {16'd0, cfg_shadow.burst_half}) begin
									toggle_led(now);
									burst_count = burst_count + 4'd1;
								end
							end else if (elapsed >= {16'd0, cfg_shadow.burst_pause}) begin
								burst_count  = '0;
								toggle_stamp = now;
							end
						end
						default: begin
						end
					endcase
				end
			end
			OP_SET: begin
				if (sel <= PAT_ERROR && sel != led_pattern) begin
					led_pattern  = sel;
					burst_count  = '0;
					toggle_stamp = now;
					pin_for_pattern();
				end
			end
			OP_IDENTIFY: begin
				identify_end = now + dur;
				if (identify_end == '0) identify_end = 32'd1;
				toggle_stamp = now;
				led_level    = 1'b1;
			end
			default: begin
			end
		endcase
		return led_level;
	endfunction

	task automatic report_mismatch(input string what, input logic want, input logic got);
		$display("%0t: %s: led_on expected %b, got %b", $time, what, want, got);
		error_count++;
	endtask

	task automatic send_item(input op_t op, input logic [31:0] now, input pattern_t sel,
			input logic [31:0] dur);
		int gap_pct;
		gap_pct = (idle_mode == 0) ? 13 : (idle_mode == 1) ? 49 : 0;
		@(negedge clk);
		if ($urandom_range(0, 99) < gap_pct) begin
			item_ch.valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		item_ch.valid                = 1'b1;
		item_ch.operation            = op;
		item_ch.now_ms               = now;
		item_ch.pattern_sel          = sel;
		item_ch.identify_duration_ms = dur;
		do @(posedge clk); while (!item_ch.ready);
		led_expected.push_back(predict_led(op, now, sel, dur));
	endtask

	// Drop valid and hold until every level has come back
	task automatic drain_results();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (led_expected.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input cfg_index_t reg_index,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = reg_index;
		cfg_ch.data  = data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (reg_index)
			REG_IDLE_HALF:     cfg_shadow.idle_half     = data;
			REG_RECEIVE_HALF:  cfg_shadow.receive_half  = data;
			REG_BURST_HALF:    cfg_shadow.burst_half    = data;
			REG_BURST_PAUSE:   cfg_shadow.burst_pause   = data;
			REG_BURST_TOGGLES: cfg_shadow.burst_toggles = data[3:0];
			REG_IDENTIFY_HALF: cfg_shadow.identify_half = data;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic apply_config(input slpg_cfg_t setting);
		logic [11:0] spare;
		spare = 12'($urandom_range(0, 4095));
		drain_results();
		write_register(REG_IDLE_HALF, setting.idle_half);
		write_register(REG_RECEIVE_HALF, setting.receive_half);
		write_register(REG_BURST_HALF, setting.burst_half);
		write_register(REG_BURST_PAUSE, setting.burst_pause);
		// upper data bits are outside the register and must be dropped
		write_register(REG_BURST_TOGGLES, {spare, setting.burst_toggles});
		write_register(REG_IDENTIFY_HALF, setting.identify_half);
	endtask

	function automatic slpg_cfg_t scaled_config(input int unsigned scale);
		slpg_cfg_t setting;
		setting.idle_half     = 16'($urandom_range(0, scale));
		setting.receive_half  = 16'($urandom_range(0, scale));
		setting.burst_half    = 16'($urandom_range(0, scale));
		setting.burst_pause   = 16'($urandom_range(0, scale));
		setting.burst_toggles = 4'($urandom_range(0, 15));
		setting.identify_half = 16'($urandom_range(0, scale));
		return setting;
	endfunction

	task automatic test_reset_state();
		send_item(OP_POLL, 32'd0, PAT_OFF, 32'd0);
		send_item(OP_UNKNOWN, 32'hFFFF_FFFF, PAT_UNUSED, 32'hFFFF_FFFF);
	endtask

	task automatic test_patterns();
		send_item(OP_SET, 32'd1000, PAT_IDLE, 32'd0);
		send_item(OP_POLL, 32'd1499, PAT_OFF, 32'd0);
		send_item(OP_POLL, 32'd1500, PAT_OFF, 32'd0);
		send_item(OP_SET, 32'd1500, PAT_RECEIVING, 32'd0);
		send_item(OP_POLL, 32'd1600, PAT_OFF, 32'd0);
		send_item(OP_SET, 32'd1600, PAT_INSTALLING, 32'd0);
		send_item(OP_POLL, 32'd1680, PAT_OFF, 32'd0);
		send_item(OP_POLL, 32'd1760, PAT_OFF, 32'd0);
		send_item(OP_SET, 32'd1800, PAT_ERROR, 32'd0);
		send_item(OP_SET, 32'd1900, PAT_ERROR, 32'd0);
		send_item(OP_SET, 32'd1900, PAT_UNUSED, 32'd0);
		send_item(OP_SET, 32'd2000, PAT_OFF, 32'd0);
	endtask

	task automatic test_identify();
		// deadline wraps to zero and is moved to one
		send_item(OP_IDENTIFY, 32'hFFFF_FF00, PAT_OFF, 32'h0000_0100);
		send_item(OP_POLL, 32'hFFFF_FF64, PAT_OFF, 32'd0);
		send_item(OP_POLL, 32'h0000_0002, PAT_OFF, 32'd0);
		// half the time range away still counts as ahead
		send_item(OP_IDENTIFY, 32'h0000_0010, PAT_OFF, 32'h8000_0000);
		send_item(OP_POLL, 32'h0000_0010, PAT_OFF, 32'd0);
		send_item(OP_IDENTIFY, 32'h0000_0020, PAT_OFF, 32'hFFFF_FFFF);
		send_item(OP_POLL, 32'h0000_0020, PAT_OFF, 32'd0);
		send_item(OP_IDENTIFY, 32'h0000_0040, PAT_OFF, 32'd0);
		send_item(OP_POLL, 32'h0000_0040, PAT_OFF, 32'd0);
	endtask

	task automatic test_zero_settings();
		apply_config('0);
		send_item(OP_SET, 32'd3000, PAT_INSTALLING, 32'd0);
		send_item(OP_POLL, 32'd3000, PAT_OFF, 32'd0);
		send_item(OP_SET, 32'd3000, PAT_IDLE, 32'd0);
		send_item(OP_POLL, 32'd3000, PAT_OFF, 32'd0);
	endtask

	task automatic test_random_traffic();
		slpg_cfg_t   setting;
		int unsigned step_max;
		int unsigned roll;
		op_t         op;
		pattern_t    sel;
		logic [31:0] dur;
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: begin
					setting  = scaled_config(12);
					step_max = 8;
				end
				1: begin
					setting  = '{16'd1, 16'd1, 16'd1, 16'd1, 4'd1, 16'd1};
					step_max = 3;
				end
				2: begin
					setting  = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF};
					step_max = 40000;
				end
				3: begin
					setting  = scaled_config(300);
					step_max = 200;
				end
				4: begin
					setting  = scaled_config(30);
					step_max = 20;
				end
				default: begin
					setting  = scaled_config(60);
					step_max = 40;
				end
			endcase
			apply_config(setting);
			idle_mode = phase / 2;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 2) begin
					sim_now = $urandom();
				end else if (roll < 3) begin
					sim_now = 32'hFFFF_FFFF - $urandom_range(0, 2 * step_max);
				end else begin
					sim_now = sim_now + $urandom_range(0, step_max);
				end
				sel  = pattern_t'($urandom_range(0, 7));
				dur  = $urandom();
				roll = $urandom_range(0, 99);
				if (roll < 4) begin
					op = OP_SET;
					if ($urandom_range(0, 9) != 0) begin
						sel = pattern_t'($urandom_range(PAT_OFF, PAT_ERROR));
					end
				end else if (roll < 8) begin
					op   = OP_IDENTIFY;
					roll = $urandom_range(0, 99);
					if (roll < 80) begin
						dur = $urandom_range(0, 6 * cfg_shadow.identify_half + step_max);
					end else if (roll < 95) begin
						dur = $urandom();
					end else begin
						dur = -sim_now;
					end
				end else if (roll < 10) begin
					op = OP_UNKNOWN;
				end else begin
					op = OP_POLL;
				end
				send_item(op, sim_now, sel, dur);
			end
		end
	endtask

	always @(negedge clk) begin
		stall_pct = (idle_mode == 0) ? 49 : (idle_mode == 1) ? 13 : 0;
		result_ch.ready = ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (led_expected.size() == 0) begin
				report_mismatch("level with no item pending", 1'bx, result_ch.led_on);
			end else if (result_ch.led_on !== led_expected[0]) begin
				report_mismatch("level mismatch", led_expected[0], result_ch.led_on);
				void'(led_expected.pop_front());
			end else begin
				void'(led_expected.pop_front());
			end
		end
	end

	// End the run when nothing moves on any channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("tb_status_led_pattern_generator: errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n                       = 1'b0;
		item_ch.valid                = 1'b0;
		item_ch.operation            = OP_POLL;
		item_ch.now_ms               = '0;
		item_ch.pattern_sel          = PAT_OFF;
		item_ch.identify_duration_ms = '0;
		result_ch.ready              = 1'b0;
		cfg_ch.valid                 = 1'b0;
		cfg_ch.index                 = REG_IDLE_HALF;
		cfg_ch.data                  = '0;
		error_count                  = 0;
		quiet_cycles                 = 0;
		idle_mode                    = 2;
		sim_now                      = $urandom();
		cfg_shadow                   = CFG_RESET;
		led_pattern                  = PAT_OFF;
		toggle_stamp                 = '0;
		identify_end                 = '0;
		burst_count                  = '0;
		led_level                    = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_patterns();
		test_identify();
		test_zero_settings();
		test_random_traffic();
		drain_results();

		if (led_expected.size() != 0) begin
			report_mismatch("levels still outstanding", led_expected[0], 1'bx);
		end
		if (error_count == 0) begin
			$display("tb_status_led_pattern_generator: clean");
		end else begin
			$display("tb_status_led_pattern_generator: errors");
		end
		$finish;
	end

endmodule
